### rtl/pmq_pkg.sv
package pmq_pkg;

  localparam int PMQ_DEPTH      = 16;
  localparam int PMQ_LOWEST_PRI = 3;

  typedef enum logic [2:0] {
    MODE_ENQ    = 3'd0,
    MODE_DEQ    = 3'd1,
    MODE_PEEK   = 3'd2,
    MODE_SEARCH = 3'd3,
    MODE_DELETE = 3'd4,
    MODE_UPDATE = 3'd5,
    MODE_LAST   = 3'd6
  } mode_t;

  typedef enum logic [2:0] {
    STAT_OK     = 3'd0,
    STAT_NONE   = 3'd1,
    STAT_DUP    = 3'd2,
    STAT_BADPRI = 3'd3,
    STAT_FULL   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_EVAL = 2'd1,
    ST_INS  = 2'd2
  } state_t;

  typedef struct packed {
    mode_t       mode;
    logic [15:0] msg_id;
    logic [2:0]  msg_priority;
    logic [31:0] msg_payload;
  } pmq_in_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] out_id;
    logic [1:0]  out_priority;
    logic [31:0] out_payload;
    logic [4:0]  occupancy;
  } pmq_out_t;

  typedef struct packed {
    logic load;
    logic eval;
    logic ins;
  } pmq_ctl_t;

  typedef struct packed {
    logic needs_ins;
  } pmq_sts_t;

endpackage

### rtl/pmq_ctrl.sv
module pmq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  pmq_pkg::pmq_sts_t sts,
  output logic              busy,
  output pmq_pkg::pmq_ctl_t ctl
);
  import pmq_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        state_nxt = sts.needs_ins ? ST_INS : ST_IDLE;
      end
      ST_INS: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    busy     = 1'b1;
    ctl.load = 1'b0;
    ctl.eval = 1'b0;
    ctl.ins  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        busy     = 1'b0;
        ctl.load = start;
      end
      ST_EVAL: begin
        ctl.eval = 1'b1;
      end
      ST_INS: begin
        ctl.ins = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

### rtl/pmq_datapath.sv
module pmq_datapath #(
  parameter int QUEUE_DEPTH     = pmq_pkg::PMQ_DEPTH,
  parameter int LOWEST_PRIORITY = pmq_pkg::PMQ_LOWEST_PRI
) (
  input  logic              clk,
  input  logic              rst_n,
  input  pmq_pkg::pmq_ctl_t ctl,
  input  pmq_pkg::pmq_in_t  in_data,
  output pmq_pkg::pmq_sts_t sts,
  output logic              out_valid,
  output pmq_pkg::pmq_out_t out_data
);
  import pmq_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int PW = $clog2(LOWEST_PRIORITY + 1);

  pmq_in_t         cmd_r;
  logic [15:0]     id_r  [QUEUE_DEPTH];
  logic [PW-1:0]   pri_r [QUEUE_DEPTH];
  logic [31:0]     pay_r [QUEUE_DEPTH];
  logic [15:0]     id_nxt  [QUEUE_DEPTH];
  logic [PW-1:0]   pri_nxt [QUEUE_DEPTH];
  logic [31:0]     pay_nxt [QUEUE_DEPTH];
  logic [CW-1:0]   count_r, count_nxt;
  logic [15:0]     sent_id_r;
  logic [PW-1:0]   sent_pri_r;
  logic [31:0]     sent_pay_r;
  logic            sent_valid_r;
  logic            sent_load;
  logic            out_valid_r;
  pmq_out_t        out_r;
  pmq_out_t        res;

  logic [QUEUE_DEPTH-1:0] match;
  logic [QUEUE_DEPTH-1:0] above;
  logic [QUEUE_DEPTH-1:0] ge;
  logic [QUEUE_DEPTH-1:0] rm_mask;
  logic [QUEUE_DEPTH-1:0] pri_col [PW];
  logic [QUEUE_DEPTH-1:0] pay_col [32];
  logic [PW-1:0]          hit_pri;
  logic [31:0]            hit_pay;
  logic [PW-1:0]          cmd_pri;
  logic [2:0]             hit_pri3, head_pri3, sent_pri3;
  logic                   found, pri_ok, full, empty;
  logic                   do_rm, do_ins, res_load;

  assign cmd_pri   = cmd_r.msg_priority[PW-1:0];
  assign found     = |match;
  assign pri_ok    = (cmd_r.msg_priority >= 3'd1) &&
                     (cmd_r.msg_priority <= 3'(LOWEST_PRIORITY));
  assign full      = (count_r == CW'(QUEUE_DEPTH));
  assign empty     = (count_r == '0);
  assign hit_pri3  = 3'(hit_pri);
  assign head_pri3 = 3'(pri_r[0]);
  assign sent_pri3 = 3'(sent_pri_r);

  // parallel compares and per-cell shift muxes
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic [15:0]   up_id, dn_id;
    logic [PW-1:0] up_pri, dn_pri;
    logic [31:0]   up_pay, dn_pay;
    logic          ge_prev;

    assign match[i] = (CW'(i) < count_r) && (id_r[i] == cmd_r.msg_id);
    assign above[i] = |match[i:0];
    assign ge[i]    = (CW'(i) >= count_r) || (pri_r[i] > cmd_pri);

    for (genvar b = 0; b < PW; b++) begin : g_prb
      assign pri_col[b][i] = match[i] & pri_r[i][b];
    end
    for (genvar b = 0; b < 32; b++) begin : g_pyb
      assign pay_col[b][i] = match[i] & pay_r[i][b];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_top
      assign up_id  = id_r[i];
      assign up_pri = pri_r[i];
      assign up_pay = pay_r[i];
    end else begin : g_mid
      assign up_id  = id_r[i+1];
      assign up_pri = pri_r[i+1];
      assign up_pay = pay_r[i+1];
    end

    if (i == 0) begin : g_bot
      assign dn_id   = id_r[i];
      assign dn_pri  = pri_r[i];
      assign dn_pay  = pay_r[i];
      assign ge_prev = 1'b0;
    end else begin : g_low
      assign dn_id   = id_r[i-1];
      assign dn_pri  = pri_r[i-1];
      assign dn_pay  = pay_r[i-1];
      assign ge_prev = ge[i-1];
    end

    always_comb begin
      id_nxt[i]  = id_r[i];
      pri_nxt[i] = pri_r[i];
      pay_nxt[i] = pay_r[i];
      if (do_rm && rm_mask[i]) begin
        id_nxt[i]  = up_id;
        pri_nxt[i] = up_pri;
        pay_nxt[i] = up_pay;
      end else if (do_ins && ge[i]) begin
        if (ge_prev) begin
          id_nxt[i]  = dn_id;
          pri_nxt[i] = dn_pri;
          pay_nxt[i] = dn_pay;
        end else begin
          id_nxt[i]  = cmd_r.msg_id;
          pri_nxt[i] = cmd_pri;
          pay_nxt[i] = cmd_r.msg_payload;
        end
      end
    end
  end

  for (genvar b = 0; b < PW; b++) begin : g_hpr
    assign hit_pri[b] = |pri_col[b];
  end
  for (genvar b = 0; b < 32; b++) begin : g_hpy
    assign hit_pay[b] = |pay_col[b];
  end

  always_comb begin
    do_rm         = 1'b0;
    do_ins        = 1'b0;
    rm_mask       = above;
    sent_load     = 1'b0;
    sts.needs_ins = 1'b0;
    count_nxt     = count_r;
    res.status       = STAT_NONE;
    res.out_id       = '0;
    res.out_priority = '0;
    res.out_payload  = '0;
    if (ctl.ins) begin
      do_ins           = 1'b1;
      count_nxt        = count_r + 1'b1;
      res.status       = STAT_OK;
      res.out_id       = cmd_r.msg_id;
      res.out_priority = cmd_r.msg_priority[1:0];
      res.out_payload  = cmd_r.msg_payload;
    end else if (ctl.eval) begin
      case (cmd_r.mode)
        MODE_ENQ: begin
          if (found) begin
            res.status = STAT_DUP;
          end else if (!pri_ok) begin
            res.status = STAT_BADPRI;
          end else if (full) begin
            res.status = STAT_FULL;
          end else begin
            do_ins           = 1'b1;
            count_nxt        = count_r + 1'b1;
            res.status       = STAT_OK;
            res.out_id       = cmd_r.msg_id;
            res.out_priority = cmd_r.msg_priority[1:0];
            res.out_payload  = cmd_r.msg_payload;
          end
        end
        MODE_DEQ, MODE_PEEK: begin
          if (!empty) begin
            res.status       = STAT_OK;
            res.out_id       = id_r[0];
            res.out_priority = head_pri3[1:0];
            res.out_payload  = pay_r[0];
            if (cmd_r.mode == MODE_DEQ) begin
              sent_load = 1'b1;
              do_rm     = 1'b1;
              rm_mask   = '1;
              count_nxt = count_r - 1'b1;
            end
          end
        end
        MODE_SEARCH, MODE_DELETE: begin
          if (found) begin
            res.status       = STAT_OK;
            res.out_id       = cmd_r.msg_id;
            res.out_priority = hit_pri3[1:0];
            res.out_payload  = hit_pay;
            if (cmd_r.mode == MODE_DELETE) begin
              do_rm     = 1'b1;
              count_nxt = count_r - 1'b1;
            end
          end
        end
        MODE_UPDATE: begin
          if (!found) begin
            res.status = STAT_NONE;
          end else if (!pri_ok) begin
            res.status = STAT_BADPRI;
          end else begin
            do_rm         = 1'b1;
            count_nxt     = count_r - 1'b1;
            sts.needs_ins = 1'b1;
          end
        end
        MODE_LAST: begin
          if (sent_valid_r) begin
            res.status       = STAT_OK;
            res.out_id       = sent_id_r;
            res.out_priority = sent_pri3[1:0];
            res.out_payload  = sent_pay_r;
          end
        end
        default: begin
          res.status = STAT_NONE;
        end
      endcase
    end
    res.occupancy = 5'(count_nxt);
    res_load = ctl.ins || (ctl.eval && !sts.needs_ins);
  end

  always_ff @(posedge clk) begin
    if (ctl.load) cmd_r <= in_data;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      id_r[i]  <= id_nxt[i];
      pri_r[i] <= pri_nxt[i];
      pay_r[i] <= pay_nxt[i];
    end
    if (res_load) out_r <= res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      sent_id_r    <= '0;
      sent_pri_r   <= '0;
      sent_pay_r   <= '0;
      sent_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= res_load;
      if (sent_load) begin
        sent_id_r    <= id_r[0];
        sent_pri_r   <= pri_r[0];
        sent_pay_r   <= pay_r[0];
        sent_valid_r <= 1'b1;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

### rtl/priority_message_queue.sv
// a request is loaded in IDLE and EVAL registers its result, but an update
// goes on to INS to re-insert; busy is high, and no request taken, outside IDLE
// the update re-insert takes a second pass through the sorted cell chain
// synchronous active-low reset empties the queue and clears the last-sent record
// results are strobed for one cycle; the receiver cannot stall
module priority_message_queue #(
  parameter int QUEUE_DEPTH     = pmq_pkg::PMQ_DEPTH,
  parameter int LOWEST_PRIORITY = pmq_pkg::PMQ_LOWEST_PRI
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  pmq_pkg::pmq_in_t  in_data,
  output logic              out_valid,
  output pmq_pkg::pmq_out_t out_data
);
  import pmq_pkg::*;

  pmq_ctl_t ctl;
  pmq_sts_t sts;

  pmq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .busy  (busy),
    .ctl   (ctl)
  );

  pmq_datapath #(
    .QUEUE_DEPTH     (QUEUE_DEPTH),
    .LOWEST_PRIORITY (LOWEST_PRIORITY)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .in_data   (in_data),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

### verif/priority_message_queue_test.sv
`timescale 1ns / 100ps

module priority_message_queue_test;
  import pmq_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int RANDOM_REQS = 1680;

  typedef struct packed {
    pmq_in_t    req;
    logic [7:0] gap;
    logic       drain_first;
  } pend_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  pmq_in_t  in_data = '0;
  logic     out_valid;
  pmq_out_t out_data;

  pend_t    pending[$];
  pmq_out_t exp_results[$];
  int       n_sent = 0;
  int       n_done = 0;
  int       errors = 0;
  int       gap_left = 0;
  int       idle_cycles = 0;
  bit       no_idle = 1'b0;

  // shadow copy of the sorted message table
  logic [15:0] tbl_id [PMQ_DEPTH];
  logic [1:0]  tbl_pri[PMQ_DEPTH];
  logic [31:0] tbl_pay[PMQ_DEPTH];
  int          tbl_count = 0;
  logic [15:0] sent_id = '0;
  logic [1:0]  sent_pri = '0;
  logic [31:0] sent_pay = '0;
  bit          sent_ok = 1'b0;

  priority_message_queue dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  always #10 clk = ~clk;

  function automatic int queue_find(input logic [15:0] id);
    for (int i = 0; i < tbl_count; i++) begin
      if (tbl_id[i] == id) return i;
    end
    return -1;
  endfunction

  function automatic void queue_remove(input int pos);
    for (int i = pos; i + 1 < tbl_count; i++) begin
      tbl_id[i]  = tbl_id[i+1];
      tbl_pri[i] = tbl_pri[i+1];
      tbl_pay[i] = tbl_pay[i+1];
    end
    tbl_count--;
  endfunction

  // new entry goes behind every entry of equal or higher priority
  function automatic void queue_insert(input logic [15:0] id, input logic [1:0] pri,
                                       input logic [31:0] pay);
    int pos;
    pos = 0;
    while (pos < tbl_count && tbl_pri[pos] <= pri) pos++;
    for (int i = tbl_count; i > pos; i--) begin
      tbl_id[i]  = tbl_id[i-1];
      tbl_pri[i] = tbl_pri[i-1];
      tbl_pay[i] = tbl_pay[i-1];
    end
    tbl_id[pos]  = id;
    tbl_pri[pos] = pri;
    tbl_pay[pos] = pay;
    tbl_count++;
  endfunction

  function automatic pmq_out_t queue_apply(input pmq_in_t req);
    pmq_out_t r;
    int       slot;
    logic     pri_ok;
    r = '0;
    r.status = STAT_NONE;
    pri_ok = req.msg_priority >= 3'd1 && req.msg_priority <= 3'(PMQ_LOWEST_PRI);
    slot = queue_find(req.msg_id);
    case (req.mode)
      MODE_ENQ: begin
        if (slot >= 0) r.status = STAT_DUP;
        else if (!pri_ok) r.status = STAT_BADPRI;
        else if (tbl_count >= PMQ_DEPTH) r.status = STAT_FULL;
        else begin
          queue_insert(req.msg_id, req.msg_priority[1:0], req.msg_payload);
          r.status = STAT_OK;
          r.out_id = req.msg_id;
          r.out_priority = req.msg_priority[1:0];
          r.out_payload = req.msg_payload;
        end
      end
      MODE_DEQ, MODE_PEEK: begin
        if (tbl_count > 0) begin
          r.status = STAT_OK;
          r.out_id = tbl_id[0];
          r.out_priority = tbl_pri[0];
          r.out_payload = tbl_pay[0];
          if (req.mode == MODE_DEQ) begin
            sent_id = tbl_id[0];
            sent_pri = tbl_pri[0];
            sent_pay = tbl_pay[0];
            sent_ok = 1'b1;
            queue_remove(0);
          end
        end
      end
      MODE_SEARCH, MODE_DELETE: begin
        if (slot >= 0) begin
          r.status = STAT_OK;
          r.out_id = tbl_id[slot];
          r.out_priority = tbl_pri[slot];
          r.out_payload = tbl_pay[slot];
          if (req.mode == MODE_DELETE) queue_remove(slot);
        end
      end
      MODE_UPDATE: begin
        if (slot < 0) r.status = STAT_NONE;
        else if (!pri_ok) r.status = STAT_BADPRI;
        else begin
          queue_remove(slot);
          queue_insert(req.msg_id, req.msg_priority[1:0], req.msg_payload);
          r.status = STAT_OK;
          r.out_id = req.msg_id;
          r.out_priority = req.msg_priority[1:0];
          r.out_payload = req.msg_payload;
        end
      end
      MODE_LAST: begin
        if (sent_ok) begin
          r.status = STAT_OK;
          r.out_id = sent_id;
          r.out_priority = sent_pri;
          r.out_payload = sent_pay;
        end
      end
      default: ;
    endcase
    r.occupancy = 5'(tbl_count);
    return r;
  endfunction

  task automatic add_req(input logic [2:0] mode, input logic [15:0] id,
                         input logic [2:0] pri, input logic [31:0] pay,
                         input bit drain = 1'b0);
    pend_t p;
    int    r;
    r = $urandom_range(0, 99);
    p.req.mode = mode_t'(mode);
    p.req.msg_id = id;
    p.req.msg_priority = pri;
    p.req.msg_payload = pay;
    p.drain_first = drain;
    if (no_idle || r < 60) p.gap = 8'd0;
    else if (r < 90) p.gap = 8'($urandom_range(1, 3));
    else p.gap = 8'($urandom_range(10, 60));
    pending.push_back(p);
  endtask

  // driver
  always @(posedge clk) begin : drive
    pend_t nxt;
    logic  take;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      take = start && !busy;
      if (take) begin
        exp_results.push_back(queue_apply(in_data));
        n_sent <= n_sent + 1;
      end
      if (!start || take) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          start <= 1'b0;
        end else if (pending.size() > 0 &&
                     (!pending[0].drain_first || (!take && n_sent == n_done))) begin
          nxt = pending.pop_front();
          start <= 1'b1;
          in_data <= nxt.req;
          gap_left <= int'(nxt.gap);
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin : check
    pmq_out_t want;
    if (rst_n && out_valid) begin
      n_done <= n_done + 1;
      if (exp_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h with no request pending", out_data);
      end else begin
        want = exp_results.pop_front();
        if (out_data.status !== want.status || out_data.out_id !== want.out_id ||
            out_data.out_priority !== want.out_priority ||
            out_data.out_payload !== want.out_payload ||
            out_data.occupancy !== want.occupancy) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: status %0d/%0d id %h/%h pri %0d/%0d pay %h/%h occ %0d/%0d",
                     want.status, out_data.status, want.out_id, out_data.out_id,
                     want.out_priority, out_data.out_priority, want.out_payload,
                     out_data.out_payload, want.occupancy, out_data.occupancy);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("priority_message_queue regression: fail");
        $finish;
      end
    end
  end

  initial begin
    logic [15:0] pool[20];
    int          cuts[3][7];
    int          kind;
    int          r;
    int          m;
    logic [15:0] id;
    logic [2:0]  pri;

    cuts[0] = '{50, 58, 64, 72, 78, 90, 96};
    cuts[1] = '{15, 45, 52, 62, 80, 88, 96};
    cuts[2] = '{30, 45, 55, 68, 78, 90, 96};
    pool[0] = 16'h0000;
    pool[1] = 16'hFFFF;
    for (int i = 2; i < 20; i++) pool[i] = 16'($urandom);

    // empty-table and nothing-sent cases, then directed cases covering every mode
    add_req(MODE_LAST, 16'h0000, 3'd0, 32'h0);
    add_req(MODE_DEQ, 16'h0000, 3'd1, 32'h0);
    add_req(MODE_PEEK, 16'hFFFF, 3'd3, 32'hFFFF_FFFF);
    add_req(MODE_SEARCH, 16'hFFFF, 3'd1, 32'h0);
    add_req(MODE_DELETE, 16'h0000, 3'd1, 32'h0);
    add_req(MODE_UPDATE, 16'h0000, 3'd2, 32'h1);
    add_req(3'd7, 16'hFFFF, 3'd7, 32'hFFFF_FFFF);
    add_req(MODE_ENQ, 16'h0000, 3'd3, 32'h0);
    add_req(MODE_ENQ, 16'hFFFF, 3'd1, 32'hFFFF_FFFF);
    add_req(MODE_ENQ, 16'h0000, 3'd0, 32'h5);
    add_req(MODE_ENQ, 16'h1234, 3'd0, 32'h6);
    add_req(MODE_ENQ, 16'h1235, 3'd7, 32'h7);
    add_req(MODE_ENQ, 16'h00AA, 3'd3, 32'h1111_2222);
    add_req(MODE_ENQ, 16'h5555, 3'd2, 32'h3333_4444);
    add_req(MODE_PEEK, 16'h0000, 3'd0, 32'h0);
    add_req(MODE_SEARCH, 16'h00AA, 3'd0, 32'h0);
    add_req(MODE_UPDATE, 16'h00AA, 3'd1, 32'hA5A5_A5A5);
    add_req(MODE_UPDATE, 16'h5555, 3'd4, 32'h9);
    add_req(MODE_UPDATE, 16'h7777, 3'd0, 32'h9);
    add_req(MODE_DELETE, 16'h5555, 3'd0, 32'h0);
    add_req(MODE_SEARCH, 16'h5555, 3'd0, 32'h0);
    add_req(MODE_DEQ, 16'h0000, 3'd0, 32'h0, 1'b1);
    add_req(MODE_LAST, 16'h0000, 3'd0, 32'h0);
    add_req(3'd7, 16'h0000, 3'd0, 32'h0);

    // fill to capacity, then past it
    for (int i = 0; i < 20; i++)
      add_req(MODE_ENQ, pool[i], 3'($urandom_range(1, 3)), $urandom);

    for (int i = 0; i < RANDOM_REQS; i++) begin
      if (i % 100 == 0) begin
        kind = $urandom_range(0, 2);
        no_idle = ($urandom_range(0, 3) == 0);
      end
      r = $urandom_range(0, 99);
      m = 7;
      for (int k = 6; k >= 0; k--) if (r < cuts[kind][k]) m = k;
      id = ($urandom_range(0, 99) < 85) ? pool[$urandom_range(0, 19)] : 16'($urandom);
      pri = ($urandom_range(0, 9) != 0) ? 3'($urandom_range(1, 3)) : 3'($urandom_range(0, 7));
      add_req(3'(m), id, pri, $urandom, $urandom_range(0, 99) == 0);
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk); while (pending.size() != 0 || start || n_done != n_sent);
    repeat (12) @(negedge clk);
    if (exp_results.size() != 0) begin
      errors++;
      $display("%0d expected results never arrived", exp_results.size());
    end
    if (errors == 0) begin
      $display("priority_message_queue regression: pass");
    end else begin
      $display("priority_message_queue regression: fail");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/pmq_pkg.sv
rtl/pmq_ctrl.sv
rtl/pmq_datapath.sv
rtl/priority_message_queue.sv
verif/priority_message_queue_test.sv
